// File: rtl/lcfp_pkg.sv
// Package for the leg command frame parser.
// Holds the transaction types, result kind codes, frame byte values and helpers.
// No dependencies.
`default_nettype none

package lcfp_pkg;

    localparam int          NUM_LEGS_DEF = 6;
    localparam int          MASK_W       = 6;
    localparam logic [7:0]  SYNC_A       = 8'd222;
    localparam logic [7:0]  SYNC_B       = 8'd230;
    localparam logic [7:0]  END_BYTE     = 8'd233;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
    localparam logic [15:0] TICK_MAX     = 16'hFFFF;

    localparam logic        CMD_BYTE = 1'b0;
    localparam logic        CMD_TICK = 1'b1;

    localparam logic [1:0]  JOINT_FOOT = 2'd2;

    typedef enum logic [2:0] {
        KIND_ANGLE    = 3'd0,
        KIND_ACCEPT   = 3'd1,
        KIND_LEN_ERR  = 3'd2,
        KIND_TOO_LONG = 3'd3,
        KIND_TIMEOUT  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC1,
        ST_SYNC2,
        ST_MASK,
        ST_BODY
    } t_sync_state;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [2:0]        leg_id;
        logic [1:0]        joint;
        logic [7:0]        angle;
        logic [MASK_W-1:0] active_mask;
    } t_out_item;

    // Mask of the leg bits that exist for a given leg count.
    function automatic logic [MASK_W-1:0] usable_mask(input int num_legs);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < num_legs) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    // Three angle bytes for each set leg bit.
    function automatic logic [4:0] expected_count(input logic [MASK_W-1:0] m);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++) begin
            n = n + {2'b00, m[i]};
        end
        return {1'b0, n, 1'b0} + {2'b00, n};
    endfunction

    // Index of the lowest set bit, zero when none is set.
    function automatic logic [2:0] lowest_leg(input logic [MASK_W-1:0] m);
        logic [2:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lcfp_in_reg.sv
// Input register stage of the leg command frame parser.
// Holds one input transaction for the parse core; depends on lcfp_pkg.
`default_nettype none

module lcfp_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  lcfp_pkg::t_in_item  i_in_item,
    output logic                o_valid,
    output lcfp_pkg::t_in_item  o_item,
    input  wire                 i_take
);
    import lcfp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lcfp_core.sv
// Parse core of the leg command frame parser: sync hunt, frame body and timeout.
// Holds the frame state, the timeout register and the result register; depends on lcfp_pkg.
`default_nettype none

module lcfp_core #(
    parameter int NUM_LEGS = lcfp_pkg::NUM_LEGS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [15:0]          i_cfg_wdata,
    input  wire                 i_valid,
    input  lcfp_pkg::t_in_item  i_item,
    output logic                o_take,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output lcfp_pkg::t_out_item o_out_item
);
    import lcfp_pkg::*;

    localparam logic [MASK_W-1:0] USABLE = usable_mask(NUM_LEGS);

    t_sync_state       r_state, n_state;
    logic [4:0]        r_byte_cnt, n_byte_cnt;
    logic [4:0]        r_expected, n_expected;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [MASK_W-1:0] r_rem, n_rem;
    logic [1:0]        r_joint, n_joint;
    logic [15:0]       r_ticks, n_ticks;
    logic [15:0]       r_timeout;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              w_fire;
    logic              w_tick;
    logic [15:0]       w_ticks_inc;
    logic              w_timeout;
    logic              w_end;
    logic              w_too_long;
    logic [4:0]        w_exp_plus1;
    logic [MASK_W-1:0] w_new_mask;

    assign o_take      = !r_out_valid || i_out_ready;
    assign w_fire      = i_valid && o_take;
    assign w_tick      = (i_item.cmd == CMD_TICK);
    assign w_ticks_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 16'd1;
    assign w_timeout   = (r_state != ST_HUNT) && (w_ticks_inc >= r_timeout);
    assign w_end       = (i_item.rx_byte == END_BYTE);
    assign w_exp_plus1 = r_expected + 5'd1;
    assign w_too_long  = (r_byte_cnt > r_expected) || (r_byte_cnt == 5'd0);
    assign w_new_mask  = i_item.rx_byte[MASK_W-1:0] & USABLE;

    always_comb begin
        n_state = r_state;
        if (w_fire) begin
            if (w_tick) begin
                if (w_timeout) begin
                    n_state = ST_HUNT;
                end
            end else begin
                case (r_state)
                    ST_HUNT, ST_SYNC1: begin
                        if (r_state == ST_SYNC1 && i_item.rx_byte == SYNC_B) begin
                            n_state = ST_SYNC2;
                        end else if (i_item.rx_byte == SYNC_A) begin
                            n_state = ST_SYNC1;
                        end else begin
                            n_state = ST_HUNT;
                        end
                    end
                    ST_SYNC2: begin
                        n_state = (i_item.rx_byte == SYNC_A) ? ST_MASK : ST_HUNT;
                    end
                    ST_MASK: begin
                        n_state = ST_BODY;
                    end
                    ST_BODY: begin
                        if (w_end || w_too_long) begin
                            n_state = ST_HUNT;
                        end
                    end
                    default: begin
                        n_state = ST_HUNT;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_byte_cnt  = r_byte_cnt;
        n_expected  = r_expected;
        n_mask      = r_mask;
        n_rem       = r_rem;
        n_joint     = r_joint;
        n_ticks     = r_ticks;
        n_out_valid = o_take ? 1'b0 : r_out_valid;
        n_out       = r_out;
        if (w_fire) begin
            n_out.kind        = KIND_ANGLE;
            n_out.leg_id      = '0;
            n_out.joint       = '0;
            n_out.angle       = '0;
            n_out.active_mask = r_mask;
            if (w_tick) begin
                if (r_state != ST_HUNT) begin
                    n_ticks = w_ticks_inc;
                end
                if (w_timeout) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_TIMEOUT;
                    n_out.active_mask = (r_state == ST_BODY) ? r_mask : '0;
                    n_byte_cnt        = '0;
                    n_expected        = '0;
                    n_mask            = '0;
                end
            end else begin
                case (r_state)
                    ST_HUNT, ST_SYNC1, ST_SYNC2: begin
                        if (i_item.rx_byte == SYNC_A &&
                            (r_state == ST_HUNT || r_state == ST_SYNC1)) begin
                            n_ticks = '0;
                        end
                    end
                    ST_MASK: begin
                        n_mask     = w_new_mask;
                        n_rem      = w_new_mask;
                        n_expected = expected_count(w_new_mask);
                        n_byte_cnt = 5'd1;
                        n_joint    = '0;
                    end
                    ST_BODY: begin
                        n_out_valid = 1'b1;
                        if (w_end || w_too_long) begin
                            if (w_end) begin
                                n_out.kind = (r_byte_cnt == w_exp_plus1) ?
                                             KIND_ACCEPT : KIND_LEN_ERR;
                            end else begin
                                n_out.kind = KIND_TOO_LONG;
                            end
                            n_byte_cnt = '0;
                            n_expected = '0;
                            n_mask     = '0;
                        end else begin
                            n_out.leg_id = lowest_leg(r_rem);
                            n_out.joint  = r_joint;
                            n_out.angle  = i_item.rx_byte;
                            n_byte_cnt   = r_byte_cnt + 5'd1;
                            if (r_joint == JOINT_FOOT) begin
                                n_joint = '0;
                                n_rem   = r_rem & (r_rem - 1'b1);
                            end else begin
                                n_joint = r_joint + 2'd1;
                            end
                        end
                    end
                    default: begin
                        n_out_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT;
            r_byte_cnt  <= '0;
            r_expected  <= '0;
            r_mask      <= '0;
            r_rem       <= '0;
            r_joint     <= '0;
            r_ticks     <= '0;
            r_timeout   <= TIMEOUT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte_cnt  <= n_byte_cnt;
            r_expected  <= n_expected;
            r_mask      <= n_mask;
            r_rem       <= n_rem;
            r_joint     <= n_joint;
            r_ticks     <= n_ticks;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/leg_command_frame_parser.sv
// Leg command frame parser: input register, parse core and result register.
// An accepted transaction passes the input register, then the core's result register.
// Throughput: one input transaction per cycle while results are taken; single-pass core.
// Reset: synchronous, active low; the parser hunts for sync, timeout returns to 1000 ticks.
// Depends on lcfp_pkg, lcfp_in_reg and lcfp_core.
`default_nettype none

module leg_command_frame_parser #(
    parameter int NUM_LEGS = lcfp_pkg::NUM_LEGS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [15:0]          i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  lcfp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output lcfp_pkg::t_out_item o_out_item
);
    import lcfp_pkg::*;

    logic     w_valid;
    logic     w_take;
    t_in_item w_item;

    lcfp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_valid    (w_valid),
        .o_item     (w_item),
        .i_take     (w_take)
    );

    lcfp_core #(
        .NUM_LEGS (NUM_LEGS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
